// ----- rtl/dpts_pkg.sv -----
package dpts_pkg;

	localparam int DEPTH      = 16;
	localparam int PRIO_BITS  = 8;
	localparam int DELAY_BITS = 16;
	localparam int IDENT_BITS = 8;

	localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam int TREE_W   = 1 << IDX_BITS;
	localparam int LVL_BITS = $clog2(IDX_BITS + 1);

	localparam logic [1:0] FUNC_ADD_READY   = 2'd0;
	localparam logic [1:0] FUNC_ADD_DELAYED = 2'd1;
	localparam logic [1:0] FUNC_TICK        = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  task_priority;
		logic [7:0]  task_ident;
		logic [15:0] delay_ticks;
	} cmd_t;

	typedef struct packed {
		logic       dispatched;
		logic [7:0] out_ident;
		logic [7:0] out_priority;
		logic       add_refused;
		logic       all_empty;
	} rsp_t;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		logic                  add;
		logic                  delayed;
		logic                  tick;
		logic                  drop;
		logic [IDX_BITS-1:0]   drop_idx;
		logic [IDX_BITS-1:0]   gone_age;
		logic [IDX_BITS-1:0]   new_age;
		logic [PRIO_BITS-1:0]  prio;
		logic [IDENT_BITS-1:0] ident;
		logic [DELAY_BITS-1:0] delay;
	} cell_ctl_t;

	// dispatch candidate as seen by the arbiter
	typedef struct packed {
		logic                  ok;
		logic [PRIO_BITS-1:0]  prio;
		logic [IDX_BITS-1:0]   age;
		logic [IDENT_BITS-1:0] ident;
		logic [IDX_BITS-1:0]   idx;
	} cand_t;

endpackage

// ----- rtl/dpts_cell.sv -----
module dpts_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [dpts_pkg::IDX_BITS-1:0] slot,
	input  dpts_pkg::cell_ctl_t           ctl,
	input  logic                          free_in,
	output logic                          free_out,
	output dpts_pkg::cand_t               cand
);

	logic                            valid_q;
	logic                            waiting_q;
	logic [dpts_pkg::DELAY_BITS-1:0] cnt_q;
	logic [dpts_pkg::PRIO_BITS-1:0]  prio_q;
	logic [dpts_pkg::IDENT_BITS-1:0] ident_q;
	logic [dpts_pkg::IDX_BITS-1:0]   age_q;
	logic                            take;
	logic                            expiring;

	// lowest free slot wins: no free cell below and this one is free
	assign take     = !valid_q && !free_in;
	assign free_out = free_in || !valid_q;
	assign expiring = cnt_q <= dpts_pkg::DELAY_BITS'(1);

	// readiness as it stands after the coming tick
	assign cand.ok    = valid_q && (!waiting_q || expiring);
	assign cand.prio  = prio_q;
	assign cand.age   = age_q;
	assign cand.ident = ident_q;
	assign cand.idx   = slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.add && take) begin
			valid_q <= 1'b1;
		end else if (ctl.drop && slot == ctl.drop_idx) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.add && take) begin
			waiting_q <= ctl.delayed;
			cnt_q     <= ctl.delayed ? ctl.delay : '0;
			prio_q    <= ctl.prio;
			ident_q   <= ctl.ident;
			age_q     <= ctl.new_age;
		end else if (ctl.tick && valid_q && waiting_q) begin
			if (expiring) begin
				cnt_q     <= '0;
				waiting_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - dpts_pkg::DELAY_BITS'(1);
			end
		end else if (ctl.drop && valid_q && slot != ctl.drop_idx && age_q > ctl.gone_age) begin
			// close the gap left by the dispatched entry
			age_q <= age_q - dpts_pkg::IDX_BITS'(1);
		end
	end

endmodule

// ----- rtl/dpts_arb.sv -----
module dpts_arb (
	input  logic                  clk,
	input  logic                  load,
	input  logic                  step,
	input  dpts_pkg::cand_t [dpts_pkg::DEPTH-1:0] cands,
	output dpts_pkg::cand_t       winner
);

	dpts_pkg::cand_t cand_q [dpts_pkg::TREE_W];

	function automatic dpts_pkg::cand_t pick(input dpts_pkg::cand_t a,
	                                         input dpts_pkg::cand_t b);
		logic b_wins;
		b_wins = b.ok && (!a.ok || b.prio > a.prio || (b.prio == a.prio && b.age < a.age));
		return b_wins ? b : a;
	endfunction

	// fold the row in half each step; entry 0 holds the winner at the end
	always_ff @(posedge clk) begin
		for (int i = 0; i < dpts_pkg::TREE_W; i++) begin
			if (load) begin
				if (i < dpts_pkg::DEPTH) begin
					cand_q[i] <= cands[i];
				end else begin
					cand_q[i] <= '0;
				end
			end else if (step) begin
				if (i < dpts_pkg::TREE_W / 2) begin
					cand_q[i] <= pick(cand_q[2*i], cand_q[2*i+1]);
				end else begin
					cand_q[i] <= '0;
				end
			end
		end
	end

	assign winner = cand_q[0];

endmodule

// ----- rtl/delayed_priority_task_scheduler.sv -----
// Adds: the done strobe follows in the cycle after accept; busy stays low, a new word may follow at once.
// Ticks: the arbiter loads every cell's candidate, the winner search folds the ready set in halves,
// then the dispatch state removes the winner and strobes done; busy falls as done rises.
// A tick holds busy high until its done strobe, so no other word is taken meanwhile.
// Reset (arst_n low) empties the table and returns the sequencer to idle.
// Results are not held: each done pulse lasts one cycle and the receiver cannot stall it.
module delayed_priority_task_scheduler (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  dpts_pkg::cmd_t cmd,
	output logic           done,
	output dpts_pkg::rsp_t rsp
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_DISP   = 3'b100
	} state_t;

	state_t                          state_q;
	logic [dpts_pkg::LVL_BITS-1:0]   lvl_q;
	logic [dpts_pkg::CNT_BITS-1:0]   count_q;
	logic                            done_q;
	dpts_pkg::rsp_t                  rsp_q;

	logic                            accept;
	logic                            is_add;
	logic                            is_tick;
	logic                            full;
	dpts_pkg::cell_ctl_t             ctl;
	dpts_pkg::cand_t [dpts_pkg::DEPTH-1:0] cands;
	logic [dpts_pkg::DEPTH:0]        free_chain;
	dpts_pkg::cand_t                 winner;
	logic [dpts_pkg::CNT_BITS-1:0]   count_after;

	assign busy    = state_q != ST_IDLE;
	assign accept  = start && !busy;
	assign is_add  = cmd.func == dpts_pkg::FUNC_ADD_READY || cmd.func == dpts_pkg::FUNC_ADD_DELAYED;
	assign is_tick = cmd.func == dpts_pkg::FUNC_TICK;
	assign full    = count_q == dpts_pkg::CNT_BITS'(dpts_pkg::DEPTH);

	always_comb begin
		ctl          = '0;
		ctl.add      = accept && is_add && !full;
		ctl.delayed  = cmd.func == dpts_pkg::FUNC_ADD_DELAYED;
		ctl.tick     = accept && is_tick;
		ctl.drop     = state_q == ST_DISP && winner.ok;
		ctl.drop_idx = winner.idx;
		ctl.gone_age = winner.age;
		ctl.new_age  = count_q[dpts_pkg::IDX_BITS-1:0];
		ctl.prio     = cmd.task_priority[dpts_pkg::PRIO_BITS-1:0];
		ctl.ident    = cmd.task_ident[dpts_pkg::IDENT_BITS-1:0];
		ctl.delay    = cmd.delay_ticks[dpts_pkg::DELAY_BITS-1:0];
	end

	assign free_chain[0] = 1'b0;

	for (genvar g = 0; g < dpts_pkg::DEPTH; g++) begin : g_cell
		dpts_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.slot     (dpts_pkg::IDX_BITS'(g)),
			.ctl      (ctl),
			.free_in  (free_chain[g]),
			.free_out (free_chain[g+1]),
			.cand     (cands[g])
		);
	end

	dpts_arb u_arb (
		.clk    (clk),
		.load   (ctl.tick),
		.step   (state_q == ST_SEARCH),
		.cands  (cands),
		.winner (winner)
	);

	assign count_after = count_q - dpts_pkg::CNT_BITS'(winner.ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lvl_q   <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_tick) begin
							lvl_q   <= '0;
							state_q <= ST_SEARCH;
						end else begin
							done_q <= 1'b1;
							if (ctl.add) begin
								count_q <= count_q + dpts_pkg::CNT_BITS'(1);
							end
						end
					end
				end
				ST_SEARCH: begin
					lvl_q <= lvl_q + dpts_pkg::LVL_BITS'(1);
					if (lvl_q == dpts_pkg::LVL_BITS'(dpts_pkg::IDX_BITS - 1)) begin
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					count_q <= count_after;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DISP) begin
			rsp_q.dispatched   <= winner.ok;
			rsp_q.out_ident    <= winner.ok ? 8'(winner.ident) : 8'd0;
			rsp_q.out_priority <= winner.ok ? 8'(winner.prio) : 8'd0;
			rsp_q.add_refused  <= 1'b0;
			rsp_q.all_empty    <= count_after == '0;
		end else if (accept && !is_tick) begin
			rsp_q.dispatched   <= 1'b0;
			rsp_q.out_ident    <= 8'd0;
			rsp_q.out_priority <= 8'd0;
			rsp_q.add_refused  <= is_add && full;
			// a successful add always leaves the table non-empty
			rsp_q.all_empty    <= !is_add && count_q == '0;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ----- tb/sv/delayed_priority_task_scheduler_tb.sv -----
`timescale 1ns / 100ps

module delayed_priority_task_scheduler_tb;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 1100;
	localparam int CYCLE_LIMIT = 400000;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	dpts_pkg::cmd_t cmd;
	logic           done;
	dpts_pkg::rsp_t rsp;

	delayed_priority_task_scheduler u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	// shadow of the task table
	bit                  occ   [dpts_pkg::DEPTH];
	bit                  waits [dpts_pkg::DEPTH];
	int unsigned         cnt   [dpts_pkg::DEPTH];
	logic [7:0]          prio  [dpts_pkg::DEPTH];
	logic [7:0]          ident [dpts_pkg::DEPTH];
	int                  rank  [dpts_pkg::DEPTH];

	dpts_pkg::cmd_t cmd_backlog[$];
	dpts_pkg::rsp_t rsp_due[$];

	bit taken;
	int gap_left;
	int calm_left;
	int error_count;
	int cycle_count;
	int words_sent;
	int n_dispatch;
	int n_refused;
	int n_idle_tick;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int count_occupied();
		int n;
		n = 0;
		for (int i = 0; i < dpts_pkg::DEPTH; i++)
			if (occ[i])
				n++;
		return n;
	endfunction

	function automatic dpts_pkg::rsp_t step_scheduler(input dpts_pkg::cmd_t c);
		dpts_pkg::rsp_t r;
		int n;
		int best;
		int gone;
		bit found;
		r = '0;
		best = 0;
		found = 1'b0;
		case (c.func)
		dpts_pkg::FUNC_ADD_READY, dpts_pkg::FUNC_ADD_DELAYED: begin
			n = count_occupied();
			r.add_refused = 1'b1;
			for (int i = 0; i < dpts_pkg::DEPTH; i++) begin
				if (!occ[i] && r.add_refused) begin
					occ[i] = 1'b1;
					waits[i] = (c.func == dpts_pkg::FUNC_ADD_DELAYED);
					cnt[i] = (c.func == dpts_pkg::FUNC_ADD_DELAYED) ? int'(c.delay_ticks) : 0;
					prio[i] = c.task_priority;
					ident[i] = c.task_ident;
					rank[i] = n;
					r.add_refused = 1'b0;
				end
			end
			if (r.add_refused)
				n_refused++;
		end
		dpts_pkg::FUNC_TICK: begin
			// advance countdowns first so newly ready tasks compete this tick
			for (int i = 0; i < dpts_pkg::DEPTH; i++) begin
				if (occ[i] && waits[i]) begin
					if (cnt[i] <= 1) begin
						cnt[i] = 0;
						waits[i] = 1'b0;
					end else begin
						cnt[i]--;
					end
				end
			end
			for (int i = 0; i < dpts_pkg::DEPTH; i++) begin
				if (occ[i] && !waits[i]) begin
					if (!found || prio[i] > prio[best] ||
					    (prio[i] == prio[best] && rank[i] < rank[best])) begin
						best = i;
						found = 1'b1;
					end
				end
			end
			if (found) begin
				r.dispatched = 1'b1;
				r.out_ident = ident[best];
				r.out_priority = prio[best];
				gone = rank[best];
				occ[best] = 1'b0;
				for (int i = 0; i < dpts_pkg::DEPTH; i++)
					if (occ[i] && rank[i] > gone)
						rank[i]--;
				n_dispatch++;
			end else begin
				n_idle_tick++;
			end
		end
		default: ;
		endcase
		r.all_empty = (count_occupied() == 0);
		return r;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, field, got, want);
		error_count++;
	endtask

	task automatic queue_word(input logic [1:0] f, input logic [7:0] p, input logic [7:0] id,
	                          input logic [15:0] dly);
		dpts_pkg::cmd_t c;
		c.func = f;
		c.task_priority = p;
		c.task_ident = id;
		c.delay_ticks = dly;
		cmd_backlog.push_back(c);
		words_sent++;
	endtask

	task automatic queue_random_add();
		logic [7:0] p;
		logic [15:0] dly;
		int r;
		// narrow priorities half the time so ties are common
		p = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 1)) begin
			if (r < 70)
				dly = 16'($urandom_range(0, 4));
			else if (r < 95)
				dly = 16'($urandom_range(5, 30));
			else
				dly = 16'($urandom_range(31, 100));
			queue_word(dpts_pkg::FUNC_ADD_DELAYED, p, 8'($urandom), dly);
		end else begin
			queue_word(dpts_pkg::FUNC_ADD_READY, p, 8'($urandom), 16'($urandom));
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			calm_left = $urandom_range(20, 80);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// driver: present the next word once the current one is taken
	always @(negedge clk) begin
		if (arst_n && (!start || taken)) begin
			taken = 1'b0;
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left--;
			end else if (cmd_backlog.size() > 0) begin
				cmd <= cmd_backlog.pop_front();
				start <= 1'b1;
				gap_left = pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check results before logging the word taken at this edge
	always @(posedge clk) begin : monitor
		dpts_pkg::rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (rsp_due.size() == 0) begin
					report_mismatch("unexpected result", int'(rsp), 0);
				end else begin
					want = rsp_due.pop_front();
					if (rsp.dispatched !== want.dispatched)
						report_mismatch("dispatched", int'(rsp.dispatched),
						                int'(want.dispatched));
					if (rsp.out_ident !== want.out_ident)
						report_mismatch("out_ident", int'(rsp.out_ident),
						                int'(want.out_ident));
					if (rsp.out_priority !== want.out_priority)
						report_mismatch("out_priority", int'(rsp.out_priority),
						                int'(want.out_priority));
					if (rsp.add_refused !== want.add_refused)
						report_mismatch("add_refused", int'(rsp.add_refused),
						                int'(want.add_refused));
					if (rsp.all_empty !== want.all_empty)
						report_mismatch("all_empty", int'(rsp.all_empty),
						                int'(want.all_empty));
				end
			end
			if (start && !busy) begin
				rsp_due.push_back(step_scheduler(cmd));
				taken = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles, %0d results outstanding",
			         cycle_count, rsp_due.size());
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int r;
		int n;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		taken = 1'b0;
		gap_left = 0;
		calm_left = 0;
		error_count = 0;
		cycle_count = 0;
		words_sent = 0;
		n_dispatch = 0;
		n_refused = 0;
		n_idle_tick = 0;

		// directed: empty table, extremes, tie order, same-tick readiness
		queue_word(dpts_pkg::FUNC_TICK, 8'h00, 8'h00, 16'h0000);
		queue_word(FUNC_UNUSED, 8'h00, 8'h00, 16'h0000);
		queue_word(dpts_pkg::FUNC_ADD_READY, 8'h00, 8'h00, 16'hFFFF);
		queue_word(dpts_pkg::FUNC_ADD_READY, 8'hFF, 8'hFF, 16'h0000);
		queue_word(dpts_pkg::FUNC_ADD_DELAYED, 8'hFF, 8'hA5, 16'h0000);
		queue_word(dpts_pkg::FUNC_ADD_DELAYED, 8'hC8, 8'h07, 16'h0001);
		queue_word(dpts_pkg::FUNC_ADD_DELAYED, 8'hFF, 8'h09, 16'h0002);
		queue_word(FUNC_UNUSED, 8'hFF, 8'hFF, 16'hFFFF);
		repeat (6)
			queue_word(dpts_pkg::FUNC_TICK, 8'h00, 8'h00, 16'h0000);
		queue_word(dpts_pkg::FUNC_ADD_DELAYED, 8'h10, 8'h5A, 16'h0003);
		queue_word(dpts_pkg::FUNC_ADD_READY, 8'h10, 8'h3C, 16'h0000);
		repeat (4)
			queue_word(dpts_pkg::FUNC_TICK, 8'h00, 8'h00, 16'h0000);

		// random: add bursts, tick bursts, table fills and some noise
		n = 0;
		while (words_sent < ITEM_TARGET - 4) begin
			r = (n == 0) ? 99 : $urandom_range(0, 99);
			n++;
			if (r < 45) begin
				repeat ($urandom_range(1, 5))
					queue_random_add();
			end else if (r < 85) begin
				repeat ($urandom_range(1, 6))
					queue_word(dpts_pkg::FUNC_TICK, 8'($urandom), 8'($urandom),
					           16'($urandom));
			end else if (r < 93) begin
				queue_word(FUNC_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom));
			end else begin
				// overfill, then drain
				repeat (dpts_pkg::DEPTH + 2)
					queue_random_add();
				repeat (dpts_pkg::DEPTH + 4)
					queue_word(dpts_pkg::FUNC_TICK, 8'h00, 8'h00, 16'h0000);
			end
		end
		// longest delays last, since they hold their slot for the rest of the run
		queue_word(dpts_pkg::FUNC_ADD_DELAYED, 8'($urandom), 8'($urandom), 16'hFFFF);
		queue_word(dpts_pkg::FUNC_ADD_DELAYED, 8'($urandom), 8'($urandom),
		           16'($urandom_range(256, 65535)));
		queue_word(dpts_pkg::FUNC_TICK, 8'h00, 8'h00, 16'h0000);
		queue_word(FUNC_UNUSED, 8'h00, 8'h00, 16'h0000);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(posedge clk);
		while (cmd_backlog.size() > 0 || start || rsp_due.size() > 0);
		repeat (12) @(posedge clk);

		while (rsp_due.size() > 0) begin
			void'(rsp_due.pop_front());
			report_mismatch("missing result", 0, 1);
		end

		$display("%0d words sent: %0d dispatches, %0d refused adds, %0d ticks with nothing ready",
		         words_sent, n_dispatch, n_refused, n_idle_tick);
		$display("%0d mismatches in %0d cycles", error_count, cycle_count);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/dpts_pkg.sv
rtl/dpts_cell.sv
rtl/dpts_arb.sv
rtl/delayed_priority_task_scheduler.sv
tb/sv/delayed_priority_task_scheduler_tb.sv
